// ===== hw/rtl/kmrb_pkg.sv =====
// Package with the constants and request types of the key matrix report builder.
package kmrb_pkg;

  localparam int unsigned ROWS      = 8;
  localparam int unsigned COLS      = 16;
  localparam int unsigned SLOTS     = 6;
  localparam int unsigned MOD_BASE  = 224;
  localparam int unsigned FN_CODE   = 255;
  localparam int unsigned OUT_SLOTS = 6;

  localparam int unsigned KEYS   = ROWS * COLS;
  localparam int unsigned KEY_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned COL_W  = 4;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RPT_W  = 16;

  localparam logic [RPT_W-1:0] REPEAT_RESET = RPT_W'(10);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LAYOUT = 1'b1;
  localparam logic LAYER_BASE = 1'b0;
  localparam logic LAYER_FN   = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              pressed;
    logic [TIME_W-1:0] now_ms;
    logic              layer_sel;
    logic [CODE_W-1:0] key_code;
  } in_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] modifier_bits;
    logic [CODE_W-1:0] slot_0;
    logic [CODE_W-1:0] slot_1;
    logic [CODE_W-1:0] slot_2;
    logic [CODE_W-1:0] slot_3;
    logic [CODE_W-1:0] slot_4;
    logic [CODE_W-1:0] slot_5;
  } out_rpt_t;

endpackage

// ===== hw/rtl/key_matrix_report_builder_core.sv =====
// Key matrix report builder: per-key debounce memory, layout memories and report state.
//
// Requests arrive on the in channel (valid/ready). A request is either a switch
// sample or a write of one layout entry into the base or function layer.
// A sample whose level differs from the stored level of that key, and whose
// time lies past the key's lockout, is taken; it produces one report request
// on the out channel, holding the modifier mask and six rollover slots. Layout writes,
// ignored samples and positions outside the matrix give nothing. The user must write
// the repeat time register via cfg_we_i/cfg_wdata_i only while idle; not enforced.
//
// One request is accepted every cycle while the intake is not stalled. The
// per-key memory and the two layout memories are read when a request is
// accepted and written back when it leaves the lookup stage; a bypass register
// forwards the write that lands on the same edge as the next read. Reset clears
// the per-key valid bits (all keys released, lockout zero), the function layer
// flag, the report and sets the repeat time to 10 ms; there is no clearing pass.
// Layout entries read before being written give undefined codes. Under a
// receiver stall the report register holds its request, one more event waits
// before it, and the intake stops once a third event reaches lookup.
module key_matrix_report_builder_core
  import kmrb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_rpt_t         out_rpt_o,
  input  logic             cfg_we_i,
  input  logic [RPT_W-1:0] cfg_wdata_i
);

  // Stored state of one key: debounced level and the end of its lockout.
  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] lockout;
  } key_state_t;

  // Configuration.
  logic [RPT_W-1:0] repeat_q;

  // Memories.
  key_state_t        key_mem   [KEYS];
  logic [CODE_W-1:0] base_mem  [KEYS];
  logic [CODE_W-1:0] fn_mem    [KEYS];
  logic [KEYS-1:0]   kvalid_q;

  // Intake.
  logic             in_acc;
  logic [KEY_W-1:0] in_key;
  logic             in_range;

  // Lookup stage.
  logic              s1_valid_q;
  in_req_t           s1_req_q;
  logic [KEY_W-1:0]  s1_key_q;
  logic              s1_range_q;
  key_state_t        krd_q;
  logic              kvalid_rd_q;
  logic [CODE_W-1:0] base_rd_q;
  logic [CODE_W-1:0] fn_rd_q;

  // Bypass of the most recent writes.
  logic              kbyp_valid_q;
  logic [KEY_W-1:0]  kbyp_key_q;
  key_state_t        kbyp_data_q;
  logic              bbyp_valid_q;
  logic [KEY_W-1:0]  bbyp_key_q;
  logic [CODE_W-1:0] bbyp_code_q;
  logic              fbyp_valid_q;
  logic [KEY_W-1:0]  fbyp_key_q;
  logic [CODE_W-1:0] fbyp_code_q;

  logic              fn_on_q;

  key_state_t        s1_kstate;
  logic [CODE_W-1:0] s1_base_code;
  logic [CODE_W-1:0] s1_fn_code;
  logic [CODE_W-1:0] s1_code;
  logic              s1_event;
  logic              s1_move;
  logic              s1_kwrite;
  logic              s1_lwrite;
  key_state_t        s1_kwdata;

  // Report stage.
  logic              e2_valid_q;
  logic [CODE_W-1:0] e2_code_q;
  logic              e2_level_q;
  logic              e2_free;
  logic              e2_move;
  logic              out_free;

  logic              out_valid_q;
  logic [CODE_W-1:0] mask_q, mask_d;
  logic [CODE_W-1:0] slots_q [SLOTS];
  logic [CODE_W-1:0] slots_d [SLOTS];

  // ---------------------------------------------------------------------------
  // Intake and memory read.
  // ---------------------------------------------------------------------------
  assign in_acc   = in_valid_i && in_ready_o;
  assign in_key   = KEY_W'(in_req_i.row) * KEY_W'(COLS) + KEY_W'(in_req_i.col);
  assign in_range = (POS_W'(in_req_i.row) < POS_W'(ROWS)) &&
                    (POS_W'(in_req_i.col) < POS_W'(COLS));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      krd_q       <= key_mem[in_key];
      kvalid_rd_q <= kvalid_q[in_key];
      base_rd_q   <= base_mem[in_key];
      fn_rd_q     <= fn_mem[in_key];
      s1_req_q    <= in_req_i;
      s1_key_q    <= in_key;
      s1_range_q  <= in_range;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup stage: merge forwarded data, decide whether the sample is taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (kbyp_valid_q && (kbyp_key_q == s1_key_q)) begin
      s1_kstate = kbyp_data_q;
    end else if (kvalid_rd_q) begin
      s1_kstate = krd_q;
    end else begin
      s1_kstate = '0;
    end
    s1_base_code = (bbyp_valid_q && (bbyp_key_q == s1_key_q)) ? bbyp_code_q : base_rd_q;
    s1_fn_code   = (fbyp_valid_q && (fbyp_key_q == s1_key_q)) ? fbyp_code_q : fn_rd_q;
    s1_code      = fn_on_q ? s1_fn_code : s1_base_code;
  end

  assign s1_event = s1_valid_q && s1_range_q && (s1_req_q.cmd == CMD_SAMPLE) &&
                    (s1_kstate.level != s1_req_q.pressed) &&
                    (s1_req_q.now_ms > s1_kstate.lockout);

  assign out_free   = !out_valid_q || out_ready_i;
  assign e2_move    = e2_valid_q && out_free;
  assign e2_free    = !e2_valid_q || out_free;
  assign s1_move    = s1_valid_q && (!s1_event || e2_free);
  assign in_ready_o = !s1_valid_q || s1_move;

  assign s1_kwrite = s1_move && s1_event;
  assign s1_lwrite = s1_move && s1_range_q && (s1_req_q.cmd == CMD_LAYOUT);

  assign s1_kwdata.level   = s1_req_q.pressed;
  assign s1_kwdata.lockout = s1_req_q.now_ms + TIME_W'(repeat_q);

  always_ff @(posedge clk_i) begin
    if (s1_kwrite) begin
      key_mem[s1_key_q] <= s1_kwdata;
    end
    if (s1_lwrite && (s1_req_q.layer_sel == LAYER_BASE)) begin
      base_mem[s1_key_q] <= s1_req_q.key_code;
    end
    if (s1_lwrite && (s1_req_q.layer_sel == LAYER_FN)) begin
      fn_mem[s1_key_q] <= s1_req_q.key_code;
    end
  end

  // Bypass payload follows the memory writes.
  always_ff @(posedge clk_i) begin
    if (s1_kwrite) begin
      kbyp_key_q  <= s1_key_q;
      kbyp_data_q <= s1_kwdata;
    end
    if (s1_lwrite && (s1_req_q.layer_sel == LAYER_BASE)) begin
      bbyp_key_q  <= s1_key_q;
      bbyp_code_q <= s1_req_q.key_code;
    end
    if (s1_lwrite && (s1_req_q.layer_sel == LAYER_FN)) begin
      fbyp_key_q  <= s1_key_q;
      fbyp_code_q <= s1_req_q.key_code;
    end
    if (s1_kwrite) begin
      e2_code_q  <= s1_code;
      e2_level_q <= s1_req_q.pressed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_q     <= REPEAT_RESET;
      kvalid_q     <= '0;
      s1_valid_q   <= 1'b0;
      kbyp_valid_q <= 1'b0;
      bbyp_valid_q <= 1'b0;
      fbyp_valid_q <= 1'b0;
      fn_on_q      <= 1'b0;
      e2_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        repeat_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_kwrite) begin
        kvalid_q[s1_key_q] <= 1'b1;
        kbyp_valid_q       <= 1'b1;
        if (s1_code == CODE_W'(FN_CODE)) begin
          fn_on_q <= s1_req_q.pressed;
        end
      end
      if (s1_lwrite && (s1_req_q.layer_sel == LAYER_BASE)) begin
        bbyp_valid_q <= 1'b1;
      end
      if (s1_lwrite && (s1_req_q.layer_sel == LAYER_FN)) begin
        fbyp_valid_q <= 1'b1;
      end
      if (s1_kwrite) begin
        e2_valid_q <= 1'b1;
      end else if (e2_move) begin
        e2_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report stage: the report state doubles as the output register, since each
  // new report is loaded exactly when it is handed to the output.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic                is_mod;
    logic [CODE_W-1:0]   off;
    logic [CODE_W-1:0]   bit_mask;
    logic                placed;
    is_mod   = ({1'b0, e2_code_q} >= (CODE_W+1)'(MOD_BASE)) &&
               ((e2_code_q - CODE_W'(MOD_BASE)) < CODE_W'(8));
    off      = e2_code_q - CODE_W'(MOD_BASE);
    bit_mask = is_mod ? (CODE_W'(1) << off[2:0]) : '0;
    placed   = 1'b0;
    mask_d   = mask_q;
    for (int i = 0; i < SLOTS; i++) begin
      slots_d[i] = slots_q[i];
    end
    if (e2_code_q == CODE_W'(FN_CODE)) begin
      mask_d = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slots_d[i] = '0;
      end
    end else if (e2_level_q) begin
      mask_d = mask_q | bit_mask;
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && (slots_q[i] == '0)) begin
          slots_d[i] = e2_code_q;
          placed     = 1'b1;
        end
      end
    end else begin
      mask_d = mask_q & ~bit_mask;
      for (int i = 0; i < SLOTS; i++) begin
        if (slots_q[i] == e2_code_q) begin
          slots_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mask_q      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slots_q[i] <= '0;
      end
    end else begin
      if (e2_move) begin
        out_valid_q <= 1'b1;
        mask_q      <= mask_d;
        for (int i = 0; i < SLOTS; i++) begin
          slots_q[i] <= slots_d[i];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slots that do not exist read as empty.
  always_comb begin
    logic [CODE_W-1:0] oslot [OUT_SLOTS];
    for (int i = 0; i < OUT_SLOTS; i++) begin
      oslot[i] = (i < SLOTS) ? slots_q[(i < SLOTS) ? i : 0] : '0;
    end
    out_rpt_o.modifier_bits = mask_q;
    out_rpt_o.slot_0        = oslot[0];
    out_rpt_o.slot_1        = oslot[1];
    out_rpt_o.slot_2        = oslot[2];
    out_rpt_o.slot_3        = oslot[3];
    out_rpt_o.slot_4        = oslot[4];
    out_rpt_o.slot_5        = oslot[5];
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A taken sample marks its key as written.
  a_kvalid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_kwrite |=> kvalid_q[$past(s1_key_q)])
    else $error("key valid bit not set after a taken sample");

  // The intake only stops when the output is blocked.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i && e2_valid_q))
    else $error("intake stalled without a blocked output");

  // A function key event empties the report.
  a_fn_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e2_move && (e2_code_q == CODE_W'(FN_CODE))) |=> (mask_q == '0))
    else $error("function key did not clear the modifier mask");

  // The report stage is only loaded when it can take the event.
  a_e2_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_kwrite |-> e2_free)
    else $error("report stage overrun");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the key matrix report builder core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kmrb_pkg::*;

  // The pause before a register write lets the core empty, since a request that
  // gives no report can still be in flight.
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam int unsigned WATCHDOG_CYCLES  = 2000;
  localparam int unsigned RANDOM_PER_PHASE = 245;
  localparam int unsigned FIELDS           = 1 + OUT_SLOTS;
  localparam int unsigned RPT_BITS         = $bits(out_rpt_t);
  localparam int unsigned HOT_KEYS         = 8;
  localparam int unsigned MAX_SHOWN        = 10;

  // Clock, reset and the signals that drive the core.
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_req_t          in_req    = '0;
  logic             out_ready = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [RPT_W-1:0] cfg_wdata = '0;
  logic             in_ready;
  logic             out_valid;
  out_rpt_t         out_rpt;

  // The testbench's own view of the core. Every array starts at zero, which is the
  // reset state: all keys released, all lockouts at zero, function layer off.
  bit [TIME_W-1:0] lockout_ms    [KEYS];
  bit              key_level     [KEYS];
  bit [CODE_W-1:0] layout_code   [2*KEYS];
  bit              layout_known  [2*KEYS];
  bit [CODE_W-1:0] rollover      [SLOTS];
  bit [CODE_W-1:0] modifier_mask;
  bit              fn_layer;
  bit [RPT_W-1:0]  repeat_ms = REPEAT_RESET;

  // Reports that the core still owes, oldest first.
  out_rpt_t pending_reports [$];

  // Traffic shaping, shared between the tests and the receiver process.
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned rx_stall   = 0;
  int unsigned hot_key    [HOT_KEYS];

  // Run statistics.
  int unsigned requests_sent   = 0;
  int unsigned samples_sent    = 0;
  int unsigned layout_sent     = 0;
  int unsigned reports_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned mismatch_count  = 0;
  int unsigned idle_cycles     = 0;

  string field_name [FIELDS] = '{"modifier_bits", "slot_0", "slot_1", "slot_2",
                                 "slot_3", "slot_4", "slot_5"};

  key_matrix_report_builder_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rpt_o   (out_rpt),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Applies one accepted request to the expected state. Returns 1 when the request
  // is a sample that gets past the debounce, together with the report it produces.
  function automatic bit build_report(input in_req_t req, output out_rpt_t rpt);
    int unsigned     key;
    int unsigned     idx;
    int unsigned     off;
    bit [CODE_W-1:0] code;
    bit [CODE_W-1:0] shown [OUT_SLOTS];
    bit              placed;
    rpt = '0;
    if (req.row >= ROWS || req.col >= COLS) return 1'b0;
    key = req.row * COLS + req.col;
    if (req.cmd == CMD_LAYOUT) begin
      idx = (req.layer_sel == LAYER_FN ? KEYS : 0) + key;
      layout_code[idx]  = req.key_code;
      layout_known[idx] = 1'b1;
      return 1'b0;
    end
    // Only a change of level past the lockout counts. The compare is a plain
    // unsigned one, so a lockout that has not wrapped blocks a time that has.
    if (key_level[key] == req.pressed || req.now_ms <= lockout_ms[key]) return 1'b0;
    key_level[key]  = req.pressed;
    lockout_ms[key] = req.now_ms + TIME_W'(repeat_ms);
    code = layout_code[(fn_layer ? KEYS : 0) + key];
    off  = code - MOD_BASE;
    if (code == FN_CODE) begin
      // The function key follows its own level and wipes the whole report.
      fn_layer      = req.pressed;
      modifier_mask = '0;
      foreach (rollover[i]) rollover[i] = '0;
    end else begin
      // Codes more than seven above the modifier base touch no modifier bit.
      if (code >= MOD_BASE && off < 8) modifier_mask[off] = req.pressed;
      if (req.pressed) begin
        placed = 1'b0;
        foreach (rollover[i]) begin
          if (!placed && rollover[i] == '0) begin
            rollover[i] = code;
            placed      = 1'b1;
          end
        end
      end else begin
        foreach (rollover[i]) begin
          if (rollover[i] == code) rollover[i] = '0;
        end
      end
    end
    foreach (shown[i]) shown[i] = (i < SLOTS) ? rollover[i] : '0;
    rpt.modifier_bits = modifier_mask;
    rpt.slot_0        = shown[0];
    rpt.slot_1        = shown[1];
    rpt.slot_2        = shown[2];
    rpt.slot_3        = shown[3];
    rpt.slot_4        = shown[4];
    rpt.slot_5        = shown[5];
    return 1'b1;
  endfunction

  // True when the request would be taken and would read a layout entry that has
  // never been written. Such a read is outside what the core promises.
  function automatic bit reads_blank_entry(input in_req_t req);
    int unsigned key;
    key = req.row * COLS + req.col;
    if (req.cmd == CMD_LAYOUT) return 1'b0;
    if (key_level[key] == req.pressed || req.now_ms <= lockout_ms[key]) return 1'b0;
    return !layout_known[(fn_layer ? KEYS : 0) + key];
  endfunction

  // Most gaps come from a low range; now and then one comes from a far higher one.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Key codes are weighted towards the interesting ones: the function key, the
  // eight modifiers, codes just too far above the modifier base, zero, and a
  // narrow band of ordinary codes so that duplicates in the slots are common.
  function automatic logic [CODE_W-1:0] random_code();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 3)  return CODE_W'(FN_CODE);
    if (p < 15) return CODE_W'(MOD_BASE + $urandom_range(0, 7));
    if (p < 20) return CODE_W'($urandom_range(MOD_BASE + 8, FN_CODE - 1));
    if (p < 23) return '0;
    if (p < 48) return CODE_W'($urandom_range(4, 7));
    return CODE_W'($urandom_range(1, MOD_BASE - 1));
  endfunction

  // Presents one request at the falling edge and holds it until the core takes it.
  // The expected state moves on at the very edge where the request is accepted.
  task automatic send_request(input in_req_t req);
    out_rpt_t    rpt;
    int unsigned gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_req   = req;
    do @(posedge clk); while (!in_ready);
    if (build_report(req, rpt)) pending_reports.push_back(rpt);
    requests_sent++;
    if (req.cmd == CMD_LAYOUT) layout_sent++;
    else samples_sent++;
    if (tx_idle_on && $urandom_range(0, 99) < 25) begin
      gap = pick_gap();
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Fields that the command ignores are left random on purpose.
  task automatic send_sample(input int unsigned row, input int unsigned col,
                             input bit level, input logic [TIME_W-1:0] now);
    in_req_t req;
    req           = in_req_t'({$urandom, $urandom});
    req.cmd       = CMD_SAMPLE;
    req.row       = ROW_W'(row);
    req.col       = COL_W'(col);
    req.pressed   = level;
    req.now_ms    = now;
    send_request(req);
  endtask

  task automatic send_layout(input int unsigned row, input int unsigned col,
                             input logic layer, input logic [CODE_W-1:0] code);
    in_req_t req;
    req           = in_req_t'({$urandom, $urandom});
    req.cmd       = CMD_LAYOUT;
    req.row       = ROW_W'(row);
    req.col       = COL_W'(col);
    req.layer_sel = layer;
    req.key_code  = code;
    send_request(req);
  endtask

  // Stops the intake and waits until every owed report has come out, then lets
  // the pipeline drain of requests that give no report.
  task automatic drain_core();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_repeat_time(input logic [RPT_W-1:0] value);
    drain_core();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    repeat_ms = value;
    cfg_writes++;
  endtask

  // Straight after reset the repeat time is 10 ms and every lockout is zero, so a
  // sample at time zero is never taken and a release must wait until past 15 ms.
  task automatic test_reset_lockout();
    send_layout(0, 0, LAYER_BASE, 8'h04);
    send_sample(0, 0, 1'b1, 32'd0);
    send_sample(0, 0, 1'b1, 32'd5);
    send_sample(0, 0, 1'b1, 32'd20);
    send_sample(0, 0, 1'b0, 32'd15);
    send_sample(0, 0, 1'b0, 32'd16);
  endtask

  // Modifier codes at both ends of the mask, a code just past the mask, code zero,
  // the extreme matrix corner, and the function key switching layers both ways.
  task automatic test_report_codes();
    send_layout(7, 15, LAYER_BASE, 8'(MOD_BASE));
    send_layout(7, 14, LAYER_BASE, 8'(MOD_BASE + 7));
    send_layout(7, 13, LAYER_BASE, 8'(MOD_BASE + 8));
    send_layout(7, 12, LAYER_BASE, 8'h00);
    send_layout(3, 3, LAYER_BASE, 8'(FN_CODE));
    send_layout(3, 3, LAYER_FN, 8'(FN_CODE));
    send_layout(3, 4, LAYER_BASE, 8'h1D);
    send_layout(3, 4, LAYER_FN, 8'h1E);
    send_sample(7, 15, 1'b1, 32'd100);
    send_sample(7, 14, 1'b1, 32'd120);
    send_sample(7, 13, 1'b1, 32'd140);
    send_sample(7, 12, 1'b1, 32'd160);
    send_sample(3, 4, 1'b1, 32'd180);
    // Function layer on: the report is cleared, and the key pressed on the base
    // layer is now released under its function layer code.
    send_sample(3, 3, 1'b1, 32'd200);
    send_sample(3, 4, 1'b0, 32'd220);
    send_sample(3, 4, 1'b1, 32'd240);
    send_sample(3, 3, 1'b0, 32'd260);
  endtask

  // A zero repeat time locks a key only for the current millisecond. The largest
  // one, taken near the top of the time range, wraps the lockout round to a small
  // value, so the very next millisecond already gets through the plain compare.
  task automatic test_repeat_extremes();
    set_repeat_time('0);
    send_layout(5, 9, LAYER_BASE, 8'h2C);
    send_sample(5, 9, 1'b1, 32'd1000);
    send_sample(5, 9, 1'b0, 32'd1000);
    send_sample(5, 9, 1'b0, 32'd1001);
    set_repeat_time('1);
    send_sample(5, 9, 1'b1, 32'hFFFF_FFF0);
    send_sample(5, 9, 1'b0, 32'hFFFF_FFFF);
  endtask

  // One random request. Most are clean level changes on a small set of busy keys,
  // timed just past their lockout, so that the slots fill up and empty again.
  // The rest are bounces inside the lockout, repeats of the stored level, layout
  // rewrites and wholly random samples.
  task automatic random_request();
    in_req_t         req;
    in_req_t         fill;
    int unsigned     key;
    int unsigned     p;
    bit [TIME_W-1:0] lock;
    req = in_req_t'({$urandom, $urandom});
    req.cmd = CMD_SAMPLE;
    key = ($urandom_range(0, 9) < 8) ? hot_key[$urandom_range(0, HOT_KEYS - 1)]
                                     : $urandom_range(0, KEYS - 1);
    req.row = ROW_W'(key / COLS);
    req.col = COL_W'(key % COLS);
    lock    = lockout_ms[key];
    p       = $urandom_range(0, 99);
    if (p < 78) begin
      req.pressed = ~key_level[key];
      // A key locked until the very last millisecond cannot change until a later
      // lockout wraps; its sample simply stays random.
      if (lock != '1) begin
        if ($urandom_range(0, 9) == 0) req.now_ms = lock + 1 + ($urandom % (~lock));
        else if (lock >= 32'hFFFF_FFC0) req.now_ms = '1;
        else req.now_ms = lock + 1 + $urandom_range(0, 40);
      end
    end else if (p < 84) begin
      req.pressed = key_level[key];
      req.now_ms  = (lock == '1) ? lock : lock + 1;
    end else if (p < 90) begin
      req.pressed = ~key_level[key];
      req.now_ms  = (lock < 64) ? TIME_W'($urandom_range(0, lock))
                                : lock - $urandom_range(0, 63);
    end else if (p < 96) begin
      req.cmd      = CMD_LAYOUT;
      req.key_code = random_code();
    end
    if (reads_blank_entry(req)) begin
      fill           = in_req_t'({$urandom, $urandom});
      fill.cmd       = CMD_LAYOUT;
      fill.row       = req.row;
      fill.col       = req.col;
      fill.layer_sel = fn_layer ? LAYER_FN : LAYER_BASE;
      fill.key_code  = random_code();
      send_request(fill);
    end
    send_request(req);
  endtask

  // Random phases under different repeat times and traffic shapes: the first runs
  // flat out on both sides, the later ones mix in gaps on one or both sides.
  task automatic test_random_traffic();
    logic [RPT_W-1:0] setting [5];
    int unsigned      last_request;
    setting[0] = '0;
    setting[1] = '1;
    setting[2] = RPT_W'($urandom_range(2, 2000));
    setting[3] = RPT_W'(1);
    setting[4] = REPEAT_RESET;
    foreach (setting[ph]) begin
      set_repeat_time(setting[ph]);
      tx_idle_on = (ph != 0 && ph != 3);
      rx_idle_on = (ph != 0 && ph != 4);
      foreach (hot_key[k]) hot_key[k] = $urandom_range(0, KEYS - 1);
      last_request = requests_sent + RANDOM_PER_PHASE;
      while (requests_sent < last_request) random_request();
    end
  endtask

  // The receiver stalls at random while gaps are enabled for it.
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
      if (rx_idle_on && $urandom_range(0, 99) < 20) rx_stall = pick_gap();
    end
  end

  // Every report taken is matched against the oldest one still owed, field by field.
  always @(posedge clk) begin
    out_rpt_t          want;
    logic [RPT_BITS-1:0] exp_bits;
    logic [RPT_BITS-1:0] got_bits;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("[%0t] report %h arrived with none expected", $realtime, out_rpt);
      end else begin
        want     = pending_reports.pop_front();
        exp_bits = want;
        got_bits = out_rpt;
        for (int i = 0; i < FIELDS; i++) begin
          if (got_bits[RPT_BITS-1-8*i -: 8] !== exp_bits[RPT_BITS-1-8*i -: 8]) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
              $display("[%0t] report %0d %s: expected %02h, got %02h", $realtime,
                       reports_checked, field_name[i], exp_bits[RPT_BITS-1-8*i -: 8],
                       got_bits[RPT_BITS-1-8*i -: 8]);
          end
        end
        reports_checked++;
      end
    end
  end

  // The run is abandoned when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no traffic for %0d cycles, %0d reports still owed",
                 idle_cycles, pending_reports.size());
        $display("key_matrix_report_builder_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_lockout();
    test_report_codes();
    test_repeat_extremes();
    test_random_traffic();
    drain_core();
    $display("Sent %0d requests (%0d switch samples, %0d layout writes), checked %0d reports.",
             requests_sent, samples_sent, layout_sent, reports_checked);
    $display("Repeat time written %0d times from 0 to 65535; %0d field mismatches.",
             cfg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("key_matrix_report_builder_core verification clean");
    end else begin
      $display("key_matrix_report_builder_core verification failed");
    end
    $finish;
  end

endmodule

// ===== key_matrix_report_builder_core.f =====
hw/rtl/kmrb_pkg.sv
hw/rtl/key_matrix_report_builder_core.sv
tb/sv/tb_top.sv
